// ----- src/ptid_pkg.sv -----
// Package for the point-to-interval distance block.
// Field widths, request and register codes, and the control/status structs
// shared by ptid_ctrl, ptid_datapath and point_to_interval_distance.
`default_nettype none

package ptid_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned POS_W  = 31;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned DIR_W  = 2;

  // Input request layout, lowest bit first
  localparam int unsigned IN_W   = 72;
  localparam int unsigned OUT_W  = 40;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  // direction register codes; the pattern 2'b10 behaves as either side
  localparam logic [DIR_W-1:0] DIR_ANY   = 2'b00;
  localparam logic [DIR_W-1:0] DIR_BELOW = 2'b01;
  localparam logic [DIR_W-1:0] DIR_ABOVE = 2'b11;

  // configuration register indexes (byte address bit 2)
  localparam logic REG_TAKE_MAX  = 1'b0;
  localparam logic REG_DIRECTION = 1'b1;

  typedef struct packed {
    logic clear;   // empty the table
    logic load;    // append one interval
    logic start;   // latch query, reset scan
    logic issue;   // read next table entry
    logic finish;  // move result to output register
  } cmd_t;

  typedef struct packed {
    logic count_zero;  // table empty
    logic idx_last;    // scan index is at the last stored entry
    logic pipe_empty;  // no read or compare in flight
    logic out_free;    // output register can take a result
  } status_t;

endpackage

`default_nettype wire

// ----- src/ptid_ctrl.sv -----
// Controller for the point-to-interval distance block.
// Sequences clear, load and query requests; drives ptid_datapath via ptid_pkg::cmd_t.
`default_nettype none

module ptid_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire ptid_pkg::mode_e   in_mode_i,
  output logic                   in_ready_o,
  input  wire ptid_pkg::status_t status_i,
  output ptid_pkg::cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   accept;

  assign accept     = in_valid_i && ready_q;
  assign in_ready_o = ready_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.clear  = accept && (in_mode_i == ptid_pkg::MODE_CLEAR);
    cmd_o.load   = accept && (in_mode_i == ptid_pkg::MODE_LOAD);
    cmd_o.start  = accept && (in_mode_i == ptid_pkg::MODE_QUERY);
    cmd_o.issue  = (state_q == ST_SCAN);
    cmd_o.finish = (state_q == ST_FINISH) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (in_mode_i == ptid_pkg::MODE_QUERY)) begin
            ready_q <= 1'b0;
            state_q <= status_i.count_zero ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status_i.idx_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (status_i.pipe_empty) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/ptid_datapath.sv -----
// Datapath for the point-to-interval distance block: interval table memory,
// fill count, scan read, candidate compare, min/max accumulator, output register.
// Uses ptid_pkg; commanded by ptid_ctrl.
`default_nettype none

module ptid_datapath #(
  parameter int unsigned MAX_INTERVALS = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ptid_pkg::cmd_t              cmd_i,
  output ptid_pkg::status_t                status_o,
  input  wire logic [ptid_pkg::CODE_W-1:0] code_i,
  input  wire logic [ptid_pkg::POS_W-1:0]  first_i,
  input  wire logic [ptid_pkg::POS_W-1:0]  last_i,
  input  wire logic                        take_max_i,
  input  wire logic [ptid_pkg::DIR_W-1:0]  direction_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ptid_pkg::DIST_W-1:0]      out_distance_o,
  output logic                             out_table_full_o
);

  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned EW = ptid_pkg::CODE_W + 2 * ptid_pkg::POS_W;
  localparam int unsigned PW = ptid_pkg::POS_W;

  // entry layout: {code, start, end}
  logic [EW-1:0] mem_q [MAX_INTERVALS];
  logic [EW-1:0] rd_q;

  logic [CW-1:0] count_q;
  logic          overflow_q;
  logic [AW-1:0] idx_q;
  logic          rd_valid_q;

  logic [ptid_pkg::CODE_W-1:0] qcode_q;
  logic [PW-1:0]               qpos_q;

  logic          cand_valid_q;
  logic [PW-1:0] cand_q;
  logic          found_q;
  logic [PW-1:0] best_q;

  logic          out_valid_q;
  logic [ptid_pkg::DIST_W-1:0] dist_q;
  logic          full_q;

  logic                        can_load;
  logic [ptid_pkg::CODE_W-1:0] e_code;
  logic [PW-1:0]               e_start;
  logic [PW-1:0]               e_end;
  logic                        contained;
  logic                        allowed;
  logic [PW-1:0]               gap;
  logic                        better;

  assign can_load = (count_q < CW'(MAX_INTERVALS));

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && can_load) begin
      mem_q[count_q[AW-1:0]] <= {code_i, first_i, last_i};
    end
    if (cmd_i.issue) begin
      rd_q <= mem_q[idx_q];
    end
  end

  assign e_code  = rd_q[EW-1 -: ptid_pkg::CODE_W];
  assign e_start = rd_q[2*PW-1 -: PW];
  assign e_end   = rd_q[PW-1:0];

  assign contained = (qpos_q >= e_start) && (qpos_q <= e_end);
  assign gap       = (qpos_q > e_end) ? (qpos_q - e_end) : (e_start - qpos_q);

  always_comb begin
    allowed = 1'b1;
    if (!contained) begin
      unique case (direction_i)
        ptid_pkg::DIR_ABOVE: allowed = !(e_start < qpos_q);
        ptid_pkg::DIR_BELOW: allowed = !(e_end > qpos_q);
        default:             allowed = 1'b1;
      endcase
    end
  end

  assign better = !found_q || (take_max_i ? (cand_q > best_q) : (cand_q < best_q));

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qcode_q <= code_i;
      qpos_q  <= first_i;
    end
    cand_q <= contained ? '0 : gap;
    if (cand_valid_q && better) begin
      best_q <= cand_q;
    end
    if (cmd_i.finish) begin
      dist_q <= found_q ? {1'b0, best_q} : '1;
      full_q <= overflow_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      overflow_q   <= 1'b0;
      idx_q        <= '0;
      rd_valid_q   <= 1'b0;
      cand_valid_q <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q    <= '0;
        overflow_q <= 1'b0;
      end else if (cmd_i.load) begin
        if (can_load) begin
          count_q <= count_q + 1'b1;
        end else begin
          overflow_q <= 1'b1;
        end
      end

      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.issue) begin
        idx_q <= idx_q + 1'b1;
      end
      rd_valid_q   <= cmd_i.issue;
      cand_valid_q <= rd_valid_q && (e_code == qcode_q) && allowed;

      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (cand_valid_q) begin
        found_q <= 1'b1;
      end

      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.count_zero = (count_q == '0);
    status_o.idx_last   = (CW'(idx_q) == count_q - 1'b1);
    status_o.pipe_empty = !rd_valid_q && !cand_valid_q;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign out_distance_o   = dist_q;
  assign out_table_full_o = full_q;

endmodule

`default_nettype wire

// ----- src/point_to_interval_distance.sv -----
// Point-to-interval distance block, top level: stream ports, APB registers,
// ptid_ctrl and ptid_datapath. Uses ptid_pkg.
//
// Requests arrive on the s_axis side. A clear or a load returns nothing;
// loads beyond MAX_INTERVALS are dropped and raise table_full until the next
// clear. A query scans the stored intervals through the table's single read
// port, one entry per cycle, and a new request is taken once its result is in
// the output register. Clearing resets only the fill count and the table_full
// flag: there is no sweep after reset. Registers (APB, 32 bit): 0x0 take_max
// (1 = largest distance, 0 = smallest), 0x4 direction (signed 2 bit: 0 either
// side, 1 intervals ending at or below the position, -1 intervals starting at
// or above it). Write them only while no query is in progress.
`default_nettype none

module point_to_interval_distance #(
  parameter int unsigned MAX_INTERVALS = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // [1:0] mode, [9:2] seq_code, [40:10] first_pos, [71:41] last_pos
  input  wire logic [ptid_pkg::IN_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // [31:0] distance, [32] table_full, [39:33] zero
  output logic [ptid_pkg::OUT_W-1:0]     m_axis_tdata,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  ptid_pkg::cmd_t    cmd;
  ptid_pkg::status_t status;
  ptid_pkg::mode_e   in_mode;

  logic                        take_max_q;
  logic [ptid_pkg::DIR_W-1:0]  direction_q;
  logic                        reg_write;
  logic [ptid_pkg::DIST_W-1:0] out_distance;
  logic                        out_table_full;

  assign in_mode = ptid_pkg::mode_e'(s_axis_tdata[1:0]);

  // configuration registers
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_max_q  <= 1'b0;
      direction_q <= '0;
    end else if (reg_write) begin
      unique case (paddr[2])
        ptid_pkg::REG_TAKE_MAX:  take_max_q  <= pwdata[0];
        ptid_pkg::REG_DIRECTION: direction_q <= pwdata[ptid_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ptid_pkg::REG_TAKE_MAX:  prdata = {31'd0, take_max_q};
      ptid_pkg::REG_DIRECTION: prdata = {{30{direction_q[1]}}, direction_q};
      default:                 prdata = '0;
    endcase
  end

  ptid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (in_mode),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ptid_datapath #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .code_i           (s_axis_tdata[9:2]),
    .first_i          (s_axis_tdata[40:10]),
    .last_i           (s_axis_tdata[71:41]),
    .take_max_i       (take_max_q),
    .direction_i      (direction_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_distance_o   (out_distance),
    .out_table_full_o (out_table_full)
  );

  assign m_axis_tdata = {7'd0, out_table_full, out_distance};

endmodule

`default_nettype wire
